@@ hdl/scwb_pkg.sv @@
// ----------------------------------------------------------------------------
// scwb_pkg: shared types and constants
// Op codes, register indexes, character constants and the command/status
// bundles between the console buffer controller and its datapath.
// ----------------------------------------------------------------------------
package scwb_pkg;

  // op field of an input word
  localparam logic [1:0] OP_RECV  = 2'd0;
  localparam logic [1:0] OP_CLEAR = 2'd1;
  localparam logic [1:0] OP_READ  = 2'd2;
  localparam logic [1:0] OP_NOP   = 2'd3;

  // configuration register indexes
  localparam logic [0:0] REG_STOP_RECEIVE = 1'b0;
  localparam logic [0:0] REG_HEX_MODE     = 1'b1;

  localparam logic [7:0] CH_NEWLINE = 8'h0A;
  localparam logic [7:0] CH_SPACE   = 8'h20;

  // which character a store writes
  localparam logic [1:0] SEL_RAW = 2'd0;
  localparam logic [1:0] SEL_HI  = 2'd1;
  localparam logic [1:0] SEL_LO  = 2'd2;
  localparam logic [1:0] SEL_SP  = 2'd3;

  localparam int IN_DATA_W   = 16;
  localparam int IN_USER_W   = 2;
  localparam int OUT_DATA_W  = 40;
  localparam int OUT_USER_W  = 1;
  localparam int CFG_INDEX_W = 1;
  localparam int CFG_DATA_W  = 1;

  typedef struct packed {
    logic       init_wr;    // clearing pass: zero one entry
    logic       load;       // capture input word
    logic       clear;      // zero pointers, count and cursor
    logic       idx_sub;    // one reduction step of the read index
    logic       rd_idx;     // read ring at read index
    logic       rd_start;   // read ring at start pointer
    logic       store;      // store one character
    logic [1:0] char_sel;
    logic       scan_step;  // advance start past the character just read
    logic       finish;     // load result register
  } cmd_t;

  typedef struct packed {
    logic [1:0] op;
    logic       stop_rx;
    logic       hex;
    logic       init_last;
    logic       idx_ok;
    logic       scroll;     // the store in progress needs a scroll
    logic       line_end;   // scanned character ends the current line
    logic       last_line;
    logic       out_free;
  } status_t;

  function automatic logic [7:0] hex_char(input logic [3:0] n);
    logic [7:0] v;
    v = {4'h0, n};
    return (n < 4'd10) ? (8'h30 + v) : (8'h37 + v);
  endfunction

endpackage

@@ hdl/scwb_ctrl.sv @@
// ----------------------------------------------------------------------------
// scwb_ctrl: console buffer sequencer
// Walks each input word through decode, character stores, scroll scans,
// index reduction and result hand-off; runs the ring clearing pass.
// ----------------------------------------------------------------------------
module scwb_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             s_tvalid,
  output logic             s_tready,
  output scwb_pkg::cmd_t   cmd,
  input  scwb_pkg::status_t st
);
  import scwb_pkg::*;

  localparam logic [3:0] S_INIT     = 4'd0;
  localparam logic [3:0] S_IDLE     = 4'd1;
  localparam logic [3:0] S_DECODE   = 4'd2;
  localparam logic [3:0] S_RD_IDX   = 4'd3;
  localparam logic [3:0] S_STORE    = 4'd4;
  localparam logic [3:0] S_SCAN_RD  = 4'd5;
  localparam logic [3:0] S_SCAN_CHK = 4'd6;
  localparam logic [3:0] S_AFTER    = 4'd7;
  localparam logic [3:0] S_DONE     = 4'd8;

  // hex mode character phase
  localparam logic [1:0] PH_HI = 2'd0;
  localparam logic [1:0] PH_LO = 2'd1;
  localparam logic [1:0] PH_SP = 2'd2;

  logic [3:0] state, state_next;
  logic [1:0] phase, phase_next;
  logic [1:0] sel;

  always_comb begin
    if (!st.hex) begin
      sel = SEL_RAW;
    end else if (phase == PH_HI) begin
      sel = SEL_HI;
    end else if (phase == PH_LO) begin
      sel = SEL_LO;
    end else begin
      sel = SEL_SP;
    end
  end

  always_comb begin
    cmd        = '0;
    state_next = state;
    phase_next = phase;
    s_tready   = 1'b0;
    case (state)
      S_INIT: begin
        cmd.init_wr = 1'b1;
        if (st.init_last) state_next = S_IDLE;
      end
      S_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          cmd.load   = 1'b1;
          state_next = S_DECODE;
        end
      end
      S_DECODE: begin
        case (st.op)
          OP_RECV: begin
            if (st.stop_rx) begin
              state_next = S_DONE;
            end else begin
              phase_next = PH_HI;
              state_next = S_STORE;
            end
          end
          OP_CLEAR: begin
            cmd.clear  = 1'b1;
            state_next = S_DONE;
          end
          OP_READ: state_next = S_RD_IDX;
          default: state_next = S_DONE;
        endcase
      end
      S_RD_IDX: begin
        if (st.idx_ok) begin
          cmd.rd_idx = 1'b1;
          state_next = S_DONE;
        end else begin
          cmd.idx_sub = 1'b1;
        end
      end
      S_STORE: begin
        cmd.store    = 1'b1;
        cmd.char_sel = sel;
        state_next   = st.scroll ? S_SCAN_RD : S_AFTER;
      end
      S_SCAN_RD: begin
        cmd.rd_start = 1'b1;
        state_next   = S_SCAN_CHK;
      end
      S_SCAN_CHK: begin
        cmd.scan_step = 1'b1;
        state_next    = (st.line_end && st.last_line) ? S_AFTER : S_SCAN_RD;
      end
      S_AFTER: begin
        if (st.hex && phase != PH_SP) begin
          phase_next = phase + 2'd1;
          state_next = S_STORE;
        end else begin
          state_next = S_DONE;
        end
      end
      S_DONE: begin
        if (st.out_free) begin
          cmd.finish = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_INIT;
      phase <= PH_HI;
    end else begin
      state <= state_next;
      phase <= phase_next;
    end
  end

endmodule

@@ hdl/scwb_dpath.sv @@
// ----------------------------------------------------------------------------
// scwb_dpath: console buffer datapath
// Character ring, pointers, count, cursor, scroll scan counters,
// configuration registers and the result register.
// ----------------------------------------------------------------------------
module scwb_dpath #(
  parameter int BUF_SIZE    = 256,
  parameter int WINDOW_COLS = 16,
  parameter int WINDOW_ROWS = 4
) (
  input  logic                                clk,
  input  logic                                rst,
  input  scwb_pkg::cmd_t                      cmd,
  output scwb_pkg::status_t                   st,
  input  logic [scwb_pkg::IN_DATA_W-1:0]      s_tdata,
  input  logic [scwb_pkg::IN_USER_W-1:0]      s_tuser,
  output logic                                m_tvalid,
  input  logic                                m_tready,
  output logic [scwb_pkg::OUT_DATA_W-1:0]     m_tdata,
  output logic [scwb_pkg::OUT_USER_W-1:0]     m_tuser,
  input  logic                                cfg_valid,
  input  logic [scwb_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  logic [scwb_pkg::CFG_DATA_W-1:0]     cfg_data
);
  import scwb_pkg::*;

  localparam int PW   = $clog2(BUF_SIZE);
  localparam int CNTW = $clog2(BUF_SIZE + 1);
  localparam int CW   = $clog2(WINDOW_COLS + 1);
  localparam int RW   = $clog2(WINDOW_ROWS + 2);

  localparam logic [PW-1:0]   LAST_POS  = PW'(BUF_SIZE - 1);
  localparam logic [CNTW-1:0] FULL_CNT  = CNTW'(BUF_SIZE);
  localparam logic [CW-1:0]   COLS      = CW'(WINDOW_COLS);
  localparam logic [CW-1:0]   LAST_COL  = CW'(WINDOW_COLS - 1);
  localparam logic [RW-1:0]   ROWS      = RW'(WINDOW_ROWS);
  localparam logic [RW-1:0]   LAST_ROW  = RW'(WINDOW_ROWS - 1);

  logic            stop_rx, hex;
  logic [1:0]      op_r;
  logic [7:0]      byte_r, idx_r;
  logic [PW-1:0]   end_ptr, start_ptr, clr_cnt;
  logic [CNTW-1:0] count;
  logic [CW-1:0]   col, col_next, kcnt;
  logic [RW-1:0]   row, row_next, nl_row;
  logic [1:0]      lines, lines_next;
  logic [7:0]      rd_data, char_in;
  logic [7:0]      mem [BUF_SIZE];

  logic [PW-1:0]   end_inc, start_inc, wr_addr, rd_addr;
  logic [7:0]      wr_data;
  logic            wr_en, rd_en;
  logic [31:0]     end_w, start_w, count_w, col_w, row_w;

  assign end_inc   = (end_ptr == LAST_POS) ? '0 : end_ptr + PW'(1);
  assign start_inc = (start_ptr == LAST_POS) ? '0 : start_ptr + PW'(1);

  always_comb begin
    case (cmd.char_sel)
      SEL_HI:  char_in = hex_char(byte_r[7:4]);
      SEL_LO:  char_in = hex_char(byte_r[3:0]);
      SEL_SP:  char_in = CH_SPACE;
      default: char_in = byte_r;
    endcase
  end

  // cursor update and number of lines to scroll for one stored character
  assign nl_row = row + ((col == COLS) ? RW'(2) : RW'(1));

  always_comb begin
    row_next   = row;
    col_next   = col;
    lines_next = 2'd0;
    if (char_in == CH_NEWLINE) begin
      col_next = '0;
      if (nl_row >= ROWS) begin
        lines_next = 2'(nl_row - LAST_ROW);
        row_next   = LAST_ROW;
      end else begin
        row_next = nl_row;
      end
    end else if (col == COLS) begin
      col_next = CW'(1);
      if (row == LAST_ROW) begin
        lines_next = 2'd1;
      end else begin
        row_next = row + RW'(1);
      end
    end else begin
      col_next = col + CW'(1);
    end
  end

  // ring port selection
  assign wr_en   = cmd.init_wr || cmd.store;
  assign wr_addr = cmd.init_wr ? clr_cnt : end_ptr;
  assign wr_data = cmd.init_wr ? 8'h00 : char_in;
  assign rd_en   = cmd.rd_idx || cmd.rd_start;
  assign rd_addr = cmd.rd_idx ? PW'(idx_r) : start_ptr;

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    if (rd_en) rd_data <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stop_rx <= 1'b0;
      hex     <= 1'b0;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_STOP_RECEIVE: stop_rx <= cfg_data[0];
        REG_HEX_MODE:     hex     <= cfg_data[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r   <= s_tuser[1:0];
      byte_r <= s_tdata[7:0];
      idx_r  <= s_tdata[15:8];
    end else if (cmd.idx_sub) begin
      idx_r <= idx_r - 8'(BUF_SIZE);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      end_ptr   <= '0;
      start_ptr <= '0;
      count     <= '0;
      col       <= '0;
      row       <= '0;
      lines     <= '0;
      kcnt      <= '0;
      clr_cnt   <= '0;
    end else begin
      if (cmd.init_wr) clr_cnt <= clr_cnt + PW'(1);
      if (cmd.clear) begin
        end_ptr   <= '0;
        start_ptr <= '0;
        count     <= '0;
        col       <= '0;
        row       <= '0;
      end else if (cmd.store) begin
        end_ptr <= end_inc;
        count   <= (count == FULL_CNT) ? count : count + CNTW'(1);
        col     <= col_next;
        row     <= row_next;
        lines   <= lines_next;
        kcnt    <= '0;
      end else if (cmd.scan_step) begin
        start_ptr <= start_inc;
        if (st.line_end) begin
          kcnt  <= '0;
          lines <= lines - 2'd1;
        end else begin
          kcnt <= kcnt + CW'(1);
        end
      end
    end
  end

  assign end_w   = 32'(end_ptr);
  assign start_w = 32'(start_ptr);
  assign count_w = 32'(count);
  assign col_w   = 32'(col);
  assign row_w   = 32'(row);

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      m_tdata <= {row_w[1:0], col_w[4:0], count_w[8:0], start_w[7:0], end_w[7:0],
                  (op_r == OP_READ) ? rd_data : 8'h00};
      m_tuser <= {(op_r == OP_RECV) && stop_rx};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.finish) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  assign st.op        = op_r;
  assign st.stop_rx   = stop_rx;
  assign st.hex       = hex;
  assign st.init_last = (clr_cnt == LAST_POS);
  assign st.idx_ok    = (32'(idx_r) < 32'(BUF_SIZE));
  assign st.scroll    = (lines_next != 2'd0);
  assign st.line_end  = (rd_data == CH_NEWLINE) || (kcnt == LAST_COL);
  assign st.last_line = (lines == 2'd1);
  assign st.out_free  = !m_tvalid || m_tready;

  a_start_range: assert property (@(posedge clk) disable iff (rst)
    32'(start_ptr) < 32'(BUF_SIZE))
    else $error("start pointer out of ring");

  a_cursor: assert property (@(posedge clk) disable iff (rst)
    (col <= COLS) && (row <= LAST_ROW))
    else $error("cursor outside window");

  a_count: assert property (@(posedge clk) disable iff (rst)
    count <= FULL_CNT)
    else $error("count above ring size");

  a_scan_lines: assert property (@(posedge clk) disable iff (rst)
    cmd.scan_step |-> (lines != 2'd0))
    else $error("scan step with no line pending");

  a_store_scroll: assert property (@(posedge clk) disable iff (rst)
    (cmd.store && lines_next != 2'd0) |=> (lines != 2'd0 && kcnt == '0))
    else $error("scroll request lost after store");

endmodule

@@ hdl/serial_console_window_buffer_unit.sv @@
// ----------------------------------------------------------------------------
// serial_console_window_buffer_unit: serial console window buffer
// Stores received bytes (raw or as hex digits) in a character ring, tracks
// cursor and count, and scrolls the window start line by line.
// ----------------------------------------------------------------------------
//  channel   direction  handshake            payload
//  s_*       in         s_tvalid / s_tready  tdata: rx_byte, read_index; tuser: op
//  m_*       out        m_tvalid / m_tready  tdata: result fields; tuser: dropped
//  cfg_*     in         cfg_valid/cfg_ready  cfg_index, cfg_data
//
//  One word at a time. Clear, no-op and dropped receive go straight to the result.
//  Read: BUF_SIZE is subtracted from the index until it lies in the ring, which is
//  then read. Receive: each character is stored; a scroll scans the window start
//  character by character (up to WINDOW_COLS per line, at most two lines) through
//  the single ring read port; hex mode stores three characters. After reset a
//  clearing pass zeroes the ring, s_tready low. The result register admits a new
//  word while the previous result waits on m_tready; the next one waits for it.
// ----------------------------------------------------------------------------
module serial_console_window_buffer_unit #(
  parameter int BUF_SIZE    = 256,
  parameter int WINDOW_COLS = 16,
  parameter int WINDOW_ROWS = 4
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             s_tvalid,
  output logic                             s_tready,
  // [7:0] rx_byte, [15:8] read_index
  input  logic [scwb_pkg::IN_DATA_W-1:0]   s_tdata,
  // [1:0] op
  input  logic [scwb_pkg::IN_USER_W-1:0]   s_tuser,
  output logic                             m_tvalid,
  input  logic                             m_tready,
  // [7:0] read_data, [15:8] end_position, [23:16] start_position,
  // [32:24] received_count, [37:33] cursor_column, [39:38] cursor_row
  output logic [scwb_pkg::OUT_DATA_W-1:0]  m_tdata,
  // [0] receive dropped (stop receive set)
  output logic [scwb_pkg::OUT_USER_W-1:0]  m_tuser,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [scwb_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [scwb_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import scwb_pkg::*;

  cmd_t    cmd;
  status_t st;

  assign cfg_ready = 1'b1;

  scwb_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .cmd      (cmd),
    .st       (st)
  );

  scwb_dpath #(
    .BUF_SIZE    (BUF_SIZE),
    .WINDOW_COLS (WINDOW_COLS),
    .WINDOW_ROWS (WINDOW_ROWS)
  ) u_dpath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .st        (st),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

endmodule
